>>> design/seven_segment_i2c_frame_builder_defines.svh
// ----------------------------------------------------------------------------
// Seven-segment frame builder assertion macros
// Shared concurrent checks, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_I2C_FRAME_BUILDER_DEFINES_SVH
`define SEVEN_SEGMENT_I2C_FRAME_BUILDER_DEFINES_SVH

`define SSFB_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("frame builder check failed");

`define SSFB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("frame builder check failed");

`endif

>>> design/ssfb_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder package
// Payload types, frame descriptor, op and register codes, segment encoding.
// ----------------------------------------------------------------------------
package ssfb_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int ADDR_WIDTH          = 7;
   localparam logic [13:0] MAX_VALUE  = 14'd9999;

   localparam logic [1:0] OP_DIGITS = 2'd0;
   localparam logic [1:0] OP_BLINK  = 2'd1;
   localparam logic [1:0] OP_RAW    = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [7:0] CMD_BLINK_ON  = 8'h83;
   localparam logic [7:0] CMD_BLINK_OFF = 8'h81;
   localparam logic [7:0] COLON_BYTE    = 8'h02;

   typedef enum logic [0:0] {
      CSR_DISPLAY_ADDR_A = 1'b0,
      CSR_DISPLAY_ADDR_B = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        display_sel;
      logic [13:0] value;
      logic        colon_on;
      logic        blink_on;
      logic [7:0]  command_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       start_before;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       is_digits;
      logic [7:0] addr_byte;
      logic [7:0] cmd;
      logic       colon;
      logic [7:0] seg_thou;
      logic [7:0] seg_hund;
      logic [7:0] seg_tens;
      logic [7:0] seg_ones;
   } desc_type;

   function automatic logic [7:0] seg_encode(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0: seg = 8'h3F;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5B;
         4'd3: seg = 8'h4F;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6D;
         4'd6: seg = 8'h7D;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

>>> design/ssfb_front.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder front end
// Accepts requests, drops unused ops, splits the value into digits over two
// stages and hands a frame descriptor to the queue.
// ----------------------------------------------------------------------------
module ssfb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  ssfb_pkg::req_type             req_payload,
   input  logic [ssfb_pkg::ADDR_WIDTH-1:0] addr_a,
   input  logic [ssfb_pkg::ADDR_WIDTH-1:0] addr_b,
   output logic                          q_push,
   input  logic                          q_full,
   output ssfb_pkg::desc_type            q_data
);
   import ssfb_pkg::*;

   typedef struct packed {
      logic       is_digits;
      logic [7:0] addr_byte;
      logic [7:0] cmd;
      logic       colon;
      logic [3:0] thou;
      logic [9:0] rem;
   } stage_type;

   typedef struct packed {
      logic [3:0]  digit;
      logic [13:0] rem;
   } split_type;

   function automatic split_type split_digit(input logic [13:0] r, input int unit);
      split_type s;
      s.digit = 4'd0;
      s.rem   = r;
      for (int d = 1; d <= 9; d++) begin
         if (r >= 14'(d * unit)) begin
            s.digit = 4'(d);
            s.rem   = r - 14'(d * unit);
         end
      end
      return s;
   endfunction

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      advance;
   logic [13:0] sat;
   split_type thou_split, hund_split, tens_split;

   always_comb begin
      advance  = !s1_valid_ff || !q_full;
      req_full = !advance;
      sat      = (req_payload.value > MAX_VALUE) ? MAX_VALUE : req_payload.value;
      thou_split = split_digit(sat, 1000);

      s1_in.is_digits = (req_payload.op == OP_DIGITS);
      s1_in.addr_byte = {req_payload.display_sel ? addr_b : addr_a, 1'b0};
      s1_in.cmd       = (req_payload.op == OP_BLINK) ?
                        (req_payload.blink_on ? CMD_BLINK_ON : CMD_BLINK_OFF) :
                        req_payload.command_byte;
      s1_in.colon     = req_payload.colon_on;
      s1_in.thou      = thou_split.digit;
      s1_in.rem       = thou_split.rem[9:0];

      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = req_push && (req_payload.op != OP_UNUSED);
      end

      hund_split = split_digit({4'd0, s1_ff.rem}, 100);
      tens_split = split_digit(hund_split.rem, 10);

      q_push           = s1_valid_ff;
      q_data.is_digits = s1_ff.is_digits;
      q_data.addr_byte = s1_ff.addr_byte;
      q_data.cmd       = s1_ff.cmd;
      q_data.colon     = s1_ff.colon;
      q_data.seg_thou  = seg_encode(s1_ff.thou);
      q_data.seg_hund  = seg_encode(hund_split.digit);
      q_data.seg_tens  = seg_encode(tens_split.digit);
      q_data.seg_ones  = seg_encode(tens_split.rem[3:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

endmodule

>>> design/ssfb_queue.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder descriptor queue
// Small FIFO of frame descriptors between front and back end.
// ----------------------------------------------------------------------------
module ssfb_queue #(
   parameter int DEPTH = ssfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  ssfb_pkg::desc_type data_in,
   output logic               empty,
   input  logic               pop,
   output ssfb_pkg::desc_type data_out
);
   import ssfb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_ok, pop_ok;

   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      push_ok  = push && !full;
      pop_ok   = pop && !empty;
      data_out = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push_ok) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

>>> design/ssfb_back.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder back end
// Walks one frame descriptor byte by byte into the output register.
// ----------------------------------------------------------------------------
module ssfb_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   output logic               q_pop,
   input  ssfb_pkg::desc_type q_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ssfb_pkg::rsp_type  rsp_payload
);
   import ssfb_pkg::*;

   localparam logic [3:0] SLOT_ADDR     = 4'd0;
   localparam logic [3:0] SLOT_POINTER  = 4'd1;
   localparam logic [3:0] SLOT_THOU     = 4'd2;
   localparam logic [3:0] SLOT_HUND     = 4'd4;
   localparam logic [3:0] SLOT_COLON    = 4'd6;
   localparam logic [3:0] SLOT_TENS     = 4'd8;
   localparam logic [3:0] SLOT_ONES     = 4'd10;
   localparam logic [3:0] SLOT_DIG_LAST = 4'd11;
   localparam logic [3:0] SLOT_CMD_LAST = 4'd1;

   logic       cur_valid_ff, cur_valid_in;
   desc_type   cur_ff, cur_in;
   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       load, last_byte;
   logic [7:0] tx;

   always_comb begin
      load      = cur_valid_ff && (!out_valid_ff || rsp_pop);
      last_byte = cur_ff.is_digits ? (idx_ff == SLOT_DIG_LAST) : (idx_ff == SLOT_CMD_LAST);
      q_pop     = !q_empty && (!cur_valid_ff || (load && last_byte));

      case (idx_ff)
         SLOT_ADDR:    tx = cur_ff.addr_byte;
         SLOT_POINTER: tx = cur_ff.is_digits ? 8'h00 : cur_ff.cmd;
         SLOT_THOU:    tx = cur_ff.seg_thou;
         SLOT_HUND:    tx = cur_ff.seg_hund;
         SLOT_COLON:   tx = cur_ff.colon ? COLON_BYTE : 8'h00;
         SLOT_TENS:    tx = cur_ff.seg_tens;
         SLOT_ONES:    tx = cur_ff.seg_ones;
         default:      tx = 8'h00;
      endcase

      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_data;
         idx_in       = '0;
      end else if (load) begin
         cur_valid_in = !last_byte;
         idx_in       = idx_ff + 1'b1;
      end

      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (load) begin
         out_valid_in        = 1'b1;
         out_in.tx_byte      = tx;
         out_in.start_before = (idx_ff == SLOT_ADDR);
         out_in.last         = last_byte;
      end

      rsp_empty   = !out_valid_ff;
      rsp_payload = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

endmodule

>>> design/seven_segment_i2c_frame_builder.sv
// ----------------------------------------------------------------------------
// Seven-segment bus frame builder
// Turns display requests into the byte stream of one bus write each.
// ----------------------------------------------------------------------------
// Requests enter through req_push/req_full as a req_type beat; bus bytes leave
// through rsp_empty/rsp_pop as rsp_type beats, oldest first.
// A digit write yields twelve bytes, a blink or raw command two, op code 3 none.
// The first byte of a frame reaches the result port by way of the front stage,
// the descriptor queue and the back end's frame and output registers; the back
// end then emits one byte per cycle while rsp_pop takes each byte. That back end
// sets the sustained request rate. The front end splits the value into digits
// in two stages and keeps taking requests while the descriptor queue has room,
// so requests queue up while the result side is stalled; req_full rises once
// the queue and the front stage are both occupied.
// The csr channel writes the two seven-bit display addresses, always ready.
// Reset is synchronous: queue, front stage and output register empty, and the
// addresses return to 0x70 and 0x71.
// ----------------------------------------------------------------------------
`include "seven_segment_i2c_frame_builder_defines.svh"

module seven_segment_i2c_frame_builder #(
   parameter int QUEUE_DEPTH = ssfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  ssfb_pkg::req_type               req_payload,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output ssfb_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  ssfb_pkg::csr_index_type         csr_index,
   input  logic [ssfb_pkg::ADDR_WIDTH-1:0] csr_wdata
);
   import ssfb_pkg::*;

   logic [ADDR_WIDTH-1:0] addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic                  fq_push, fq_full, bq_empty, bq_pop;
   desc_type              fq_data, bq_data;

   assign csr_ready = 1'b1;

   always_comb begin
      addr_a_in = addr_a_ff;
      addr_b_in = addr_b_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DISPLAY_ADDR_A: addr_a_in = csr_wdata;
            CSR_DISPLAY_ADDR_B: addr_b_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_a_ff <= 7'd112;
         addr_b_ff <= 7'd113;
      end else begin
         addr_a_ff <= addr_a_in;
         addr_b_ff <= addr_b_in;
      end
   end

   ssfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .addr_a      (addr_a_ff),
      .addr_b      (addr_b_ff),
      .q_push      (fq_push),
      .q_full      (fq_full),
      .q_data      (fq_data)
   );

   ssfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .full     (fq_full),
      .data_in  (fq_data),
      .empty    (bq_empty),
      .pop      (bq_pop),
      .data_out (bq_data)
   );

   ssfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (bq_empty),
      .q_pop       (bq_pop),
      .q_data      (bq_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   `SSFB_ASSERT_NEXT(a_req_reaches_stage, clock, reset,
      req_push && !req_full && (req_payload.op != OP_UNUSED), fq_push)
   `SSFB_ASSERT_NEXT(a_frame_no_gap, clock, reset,
      !rsp_empty && rsp_pop && !rsp_payload.last, !rsp_empty)
   `SSFB_ASSERT_NEXT(a_start_after_last_only, clock, reset,
      !rsp_empty && rsp_pop && !rsp_payload.last, !rsp_payload.start_before)

endmodule

>>> tb/seven_segment_i2c_frame_builder_tb.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder testbench
// Drives display requests and address writes through the queue-style ports,
// predicts the bus byte stream of every accepted request and checks each
// popped byte in order, with random idle bursts on both sides of the block.
// ----------------------------------------------------------------------------
module seven_segment_i2c_frame_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssfb_pkg::*;

   localparam logic [9:0][7:0] GLYPH = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                        8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};
   localparam int RANDOM_PER_PHASE = 90;
   localparam int SETTLE_CYCLES    = 12;

   class frame_scoreboard;
      logic [6:0] addr_a;
      logic [6:0] addr_b;
      rsp_type    pending_bytes[$];
      int         mismatches;

      function new();
         addr_a      = 7'd112;
         addr_b      = 7'd113;
         mismatches  = 0;
      endfunction

      function void set_address(csr_index_type idx, logic [6:0] addr);
         case (idx)
            CSR_DISPLAY_ADDR_A: addr_a = addr;
            CSR_DISPLAY_ADDR_B: addr_b = addr;
            default: ;
         endcase
      endfunction

      function void note_request(req_type r);
         logic [7:0]  frame[$];
         logic [7:0]  cells[5];
         logic [13:0] v;
         logic [7:0]  addr_byte;
         rsp_type     b;
         addr_byte = {(r.display_sel ? addr_b : addr_a), 1'b0};
         case (r.op)
            OP_DIGITS: begin
               v = (r.value > MAX_VALUE) ? MAX_VALUE : r.value;
               cells[0] = GLYPH[(v / 1000) % 10];
               cells[1] = GLYPH[(v / 100) % 10];
               cells[2] = r.colon_on ? COLON_BYTE : 8'h00;
               cells[3] = GLYPH[(v / 10) % 10];
               cells[4] = GLYPH[v % 10];
               frame.push_back(addr_byte);
               frame.push_back(8'h00);
               for (int i = 0; i < 5; i++) begin
                  frame.push_back(cells[i]);
                  frame.push_back(8'h00);
               end
            end
            OP_BLINK: begin
               frame.push_back(addr_byte);
               frame.push_back(r.blink_on ? CMD_BLINK_ON : CMD_BLINK_OFF);
            end
            OP_RAW: begin
               frame.push_back(addr_byte);
               frame.push_back(r.command_byte);
            end
            default: ;
         endcase
         for (int k = 0; k < frame.size(); k++) begin
            b.tx_byte      = frame[k];
            b.start_before = (k == 0);
            b.last         = (k == frame.size() - 1);
            pending_bytes.push_back(b);
         end
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected bus byte %h start %b last %b", got.tx_byte,
                        got.start_before, got.last);
            return;
         end
         want = pending_bytes.pop_front();
         if (got.tx_byte !== want.tx_byte || got.start_before !== want.start_before ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("bus byte mismatch: expected %h/%b/%b got %h/%b/%b",
                        want.tx_byte, want.start_before, want.last,
                        got.tx_byte, got.start_before, got.last);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   logic                  req_full;
   req_type               req_payload = '0;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_DISPLAY_ADDR_A;
   logic [ADDR_WIDTH-1:0] csr_wdata = '0;
   logic                  calm      = 1'b0;

   frame_scoreboard sb = new();

   seven_segment_i2c_frame_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.set_address(csr_index, csr_wdata);
         if (req_push && !req_full)
            sb.note_request(req_payload);
         if (rsp_pop && !rsp_empty)
            sb.check_byte(rsp_payload);
      end
   end

   initial begin : pop_driver
      int run;
      @(posedge clock);
      forever begin
         if (calm) begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(0, 2) != 0);
            run = $urandom_range(1, 9);
            repeat (run) @(posedge clock);
         end
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic sel, logic [13:0] value,
                                        logic colon, logic blink, logic [7:0] cmd);
      req_type r;
      r.op           = op;
      r.display_sel  = sel;
      r.value        = value;
      r.colon_on     = colon;
      r.blink_on     = blink;
      r.command_byte = cmd;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      r    = req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 19);
      if (pick == 0)
         r.op = OP_UNUSED;
      else if (pick < 12)
         r.op = OP_DIGITS;
      else if (pick < 16)
         r.op = OP_BLINK;
      else
         r.op = OP_RAW;
      if ($urandom_range(0, 6) != 0)
         r.value = 14'($urandom_range(0, 9999));
      return r;
   endfunction

   task automatic send_request(input req_type r);
      req_payload <= r;
      req_push    <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic write_addresses(input logic [6:0] addr_a, input logic [6:0] addr_b);
      csr_valid <= 1'b1;
      csr_index <= CSR_DISPLAY_ADDR_A;
      csr_wdata <= addr_a;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_DISPLAY_ADDR_B;
      csr_wdata <= addr_b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input logic [6:0] addr_a, input logic [6:0] addr_b);
      write_addresses(addr_a, addr_b);
      repeat (RANDOM_PER_PHASE) send_request(random_req());
      drain();
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_req(OP_DIGITS, 1'b0, 14'd0,     1'b0, 1'b0, 8'h00));
      send_request(make_req(OP_DIGITS, 1'b1, 14'd9999,  1'b1, 1'b1, 8'hFF));
      send_request(make_req(OP_DIGITS, 1'b0, 14'd1234,  1'b1, 1'b0, 8'h00));
      send_request(make_req(OP_DIGITS, 1'b1, 14'd5678,  1'b0, 1'b0, 8'h00));
      send_request(make_req(OP_DIGITS, 1'b0, 14'd9090,  1'b0, 1'b1, 8'h00));
      send_request(make_req(OP_DIGITS, 1'b1, 14'd10000, 1'b1, 1'b0, 8'h00));
      send_request(make_req(OP_DIGITS, 1'b0, 14'd16383, 1'b0, 1'b0, 8'h00));
      send_request(make_req(OP_DIGITS, 1'b1, 14'd8191,  1'b1, 1'b0, 8'h00));
      send_request(make_req(OP_DIGITS, 1'b0, 14'd9,     1'b0, 1'b0, 8'h00));
      send_request(make_req(OP_BLINK,  1'b0, 14'd0,     1'b0, 1'b1, 8'h00));
      send_request(make_req(OP_BLINK,  1'b1, 14'd0,     1'b0, 1'b0, 8'h00));
      send_request(make_req(OP_RAW,    1'b0, 14'd0,     1'b0, 1'b0, 8'h00));
      send_request(make_req(OP_RAW,    1'b1, 14'd0,     1'b0, 1'b0, 8'hFF));
      send_request(make_req(OP_RAW,    1'b0, 14'd0,     1'b0, 1'b0, 8'hA5));
      send_request(make_req(OP_UNUSED, 1'b0, 14'd4321,  1'b1, 1'b1, 8'h5A));
      send_request(make_req(OP_UNUSED, 1'b1, 14'd16383, 1'b1, 1'b1, 8'hFF));
      send_request(make_req(OP_BLINK,  1'b1, 14'd0,     1'b0, 1'b1, 8'h00));
      drain();

      random_phase(7'd0, 7'd127);
      random_phase(7'd127, 7'd0);
      random_phase(7'h2A, 7'h55);
      calm <= 1'b1;
      random_phase(7'($urandom), 7'($urandom));

      if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
